FILE: hw/rtl/utt_pkg.sv
package utt_pkg;

  // kinds of result item
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLEAN = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  localparam int CP_W = 21;

  // code unit tags in bits 15:10
  localparam logic [5:0] HIGH_TAG = 6'h36;
  localparam logic [5:0] LOW_TAG  = 6'h37;

  // supplementary plane offset
  localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

  // utf-8 length thresholds
  localparam logic [CP_W-1:0] LIM_ONE   = 21'h80;
  localparam logic [CP_W-1:0] LIM_TWO   = 21'h800;
  localparam logic [CP_W-1:0] LIM_THREE = 21'h10000;

  localparam int QUEUE_DEPTH = 2;

  // one decoded job: a code point to encode and an optional end marker
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic [2:0]      ndata;
    kind_t           kind;
  } job_t;

endpackage

FILE: hw/rtl/utt_in_if.sv
interface utt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: hw/rtl/utt_out_if.sv
interface utt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       out_last;

  modport source (output valid, output out_byte, output out_kind, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input out_kind, input out_last,
                  output ready);
endinterface

FILE: hw/rtl/utt_front.sv
module utt_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  utt_in_if.sink          in_chan,
  input  logic            q_full,
  output logic            q_push,
  output utt_pkg::job_t   q_job
);

  logic       big_endian_r;
  logic       phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       pend_r, pend_nxt;
  logic [9:0] hbits_r, hbits_nxt;
  logic       stopped_r, stopped_nxt;

  logic        accept;
  logic [15:0] unit;
  logic        is_high;
  logic        is_low;
  logic [utt_pkg::CP_W-1:0] pair_cp;
  logic [utt_pkg::CP_W-1:0] cp;
  logic        has_cp;
  logic        err;
  logic        clear;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;

  // code unit assembly and classification
  assign unit    = big_endian_r ? {held_r, in_chan.in_byte} : {in_chan.in_byte, held_r};
  assign is_high = unit[15:10] == utt_pkg::HIGH_TAG;
  assign is_low  = unit[15:10] == utt_pkg::LOW_TAG;
  assign pair_cp = {1'b0, hbits_r, unit[9:0]} + utt_pkg::SUPP_BASE;

  // per-item decode
  always_comb begin
    phase_nxt   = phase_r;
    held_nxt    = held_r;
    pend_nxt    = pend_r;
    hbits_nxt   = hbits_r;
    stopped_nxt = stopped_r;
    cp          = '0;
    has_cp      = 1'b0;
    err         = 1'b0;
    clear       = 1'b0;
    if (stopped_r) begin
      clear = in_chan.in_last;
    end else if (!phase_r) begin
      held_nxt  = in_chan.in_byte;
      phase_nxt = 1'b1;
      err       = in_chan.in_last;
    end else begin
      phase_nxt = 1'b0;
      held_nxt  = '0;
      priority if (pend_r) begin
        if (is_low) begin
          cp        = pair_cp;
          has_cp    = 1'b1;
          pend_nxt  = 1'b0;
          hbits_nxt = '0;
        end else begin
          err = 1'b1;
        end
      end else if (is_high) begin
        if (in_chan.in_last) begin
          err = 1'b1;
        end else begin
          pend_nxt  = 1'b1;
          hbits_nxt = unit[9:0];
        end
      end else if (is_low) begin
        err = 1'b1;
      end else begin
        cp     = {5'b0, unit};
        has_cp = 1'b1;
      end
    end
    if (!stopped_r) begin
      if (err && !in_chan.in_last) begin
        stopped_nxt = 1'b1;
      end
      if (in_chan.in_last) begin
        clear = 1'b1;
      end
    end
    if (clear) begin
      phase_nxt   = 1'b0;
      held_nxt    = '0;
      pend_nxt    = 1'b0;
      hbits_nxt   = '0;
      stopped_nxt = 1'b0;
    end
  end

  // job for the queue
  always_comb begin
    q_job.cp = cp;
    priority if (!has_cp) begin
      q_job.ndata = 3'd0;
    end else if (cp < utt_pkg::LIM_ONE) begin
      q_job.ndata = 3'd1;
    end else if (cp < utt_pkg::LIM_TWO) begin
      q_job.ndata = 3'd2;
    end else if (cp < utt_pkg::LIM_THREE) begin
      q_job.ndata = 3'd3;
    end else begin
      q_job.ndata = 3'd4;
    end
    priority if (err) begin
      q_job.kind = utt_pkg::KIND_ERROR;
    end else if (in_chan.in_last && !stopped_r) begin
      q_job.kind = utt_pkg::KIND_CLEAN;
    end else begin
      q_job.kind = utt_pkg::KIND_DATA;
    end
  end

  assign q_push = accept && (has_cp || err || (in_chan.in_last && !stopped_r));

  // string state and configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r <= 1'b0;
      phase_r      <= 1'b0;
      held_r       <= '0;
      pend_r       <= 1'b0;
      hbits_r      <= '0;
      stopped_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        big_endian_r <= cfg_wdata;
      end
      if (accept) begin
        phase_r   <= phase_nxt;
        held_r    <= held_nxt;
        pend_r    <= pend_nxt;
        hbits_r   <= hbits_nxt;
        stopped_r <= stopped_nxt;
      end
    end
  end

endmodule

FILE: hw/rtl/utt_fifo.sv
module utt_fifo #(
  parameter int Depth = utt_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  utt_pkg::job_t wr_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output utt_pkg::job_t head_job
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  utt_pkg::job_t  mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] cnt_r;

  assign full       = cnt_r == FullCnt;
  assign head_valid = cnt_r != '0;
  assign head_job   = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/utt_back.sv
module utt_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  utt_pkg::job_t head_job,
  output logic          pop,
  utt_out_if.source     out_chan
);

  logic [2:0] idx_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic [1:0] out_kind_r;
  logic       out_last_r;

  logic [2:0] total;
  logic [2:0] rem;
  logic       final_res;
  logic       load;
  logic [7:0] res_byte;
  logic [1:0] res_kind;

  assign total     = head_job.ndata + {2'b0, head_job.kind != utt_pkg::KIND_DATA};
  assign final_res = idx_r == total - 3'd1;
  assign load      = head_valid && (!out_valid_r || out_chan.ready);
  assign pop       = load && final_res;
  assign rem       = head_job.ndata - idx_r - 3'd1;

  // utf-8 byte selection
  always_comb begin
    res_byte = '0;
    res_kind = utt_pkg::KIND_DATA;
    if (idx_r >= head_job.ndata) begin
      res_kind = head_job.kind;
    end else if (idx_r == 3'd0) begin
      unique case (head_job.ndata)
        3'd1:    res_byte = {1'b0, head_job.cp[6:0]};
        3'd2:    res_byte = {3'b110, head_job.cp[10:6]};
        3'd3:    res_byte = {4'b1110, head_job.cp[15:12]};
        default: res_byte = {5'b11110, head_job.cp[20:18]};
      endcase
    end else begin
      unique case (rem)
        3'd0:    res_byte = {2'b10, head_job.cp[5:0]};
        3'd1:    res_byte = {2'b10, head_job.cp[11:6]};
        default: res_byte = {2'b10, head_job.cp[17:12]};
      endcase
    end
  end

  // result index and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r       <= final_res ? 3'd0 : idx_r + 3'd1;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= res_byte;
      out_kind_r <= res_kind;
      out_last_r <= final_res;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_byte = out_byte_r;
  assign out_chan.out_kind = out_kind_r;
  assign out_chan.out_last = out_last_r;

endmodule

FILE: hw/rtl/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder
// in_chan carries one UTF-16 byte per item with in_last on the final byte of a
// string; cfg_we/cfg_wdata set the byte order (1 = high byte first) between
// strings. out_chan gives UTF-8 bytes (kind 0) and one end marker per string:
// kind 1 for a clean end, kind 2 on a bad surrogate or an odd trailing byte.
// After an error the rest of the string is dropped up to its last byte.
// out_last marks the final result caused by one input item.
// The front decoder takes one byte per cycle while its job queue has room and
// pushes at most one job per item. The back encoder sends one result per cycle
// while the receiver is ready, from the queue head through an output register;
// an item's first result passes a queue entry and then the output register. An
// item gives zero to five results, one per output cycle, and the output side sets
// the sustained rate. A stalled receiver holds the output register; the queue
// then fills and in_chan.ready drops. Reset clears the string state, the queue
// and the output valid, and sets little-endian order.
module utf16_to_utf8_transcoder #(
  parameter int QueueDepth = utt_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  utt_in_if.sink    in_chan,
  utt_out_if.source out_chan
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          head_valid;
  utt_pkg::job_t push_job;
  utt_pkg::job_t head_job;

  // byte pairing and surrogate decode
  utt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  // job queue between decode and encode
  utt_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .wr_job     (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // utf-8 encode and output
  utt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (q_pop),
    .out_chan   (out_chan)
  );

endmodule

FILE: test/testbench.sv
module testbench;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int REPORT_MAX   = 10;
  localparam int PHASE_ITEMS  = 80;

  // directed rows carry up to three typed-in results as {kind, byte}
  localparam logic [9:0] ERROR_END = {utt_pkg::KIND_ERROR, 8'h00};
  localparam logic [9:0] NO_ITEM   = 10'h000;

  typedef struct packed {
    logic [7:0]     b;
    utt_pkg::kind_t kind;
    logic           last;
  } utf8_res_t;

  typedef struct {
    logic [7:0]       b;
    logic             last;
    bit               typed;
    int               cnt;
    logic [2:0][9:0]  want;
  } stim_row_t;

  // ways of breaking a random string
  typedef enum int {
    FLAW_NONE,
    FLAW_LONE_LOW,
    FLAW_BAD_PAIR,
    FLAW_HIGH_AT_END,
    FLAW_ODD_BYTE,
    FLAW_NOISE
  } flaw_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic src_valid = 1'b0;
  logic [7:0] src_byte = 8'h00;
  logic src_last = 1'b0;
  logic sink_ready = 1'b0;

  bit idle_on = 1'b1;
  int stall_left = 0;
  int items_sent = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // typed-in expectation of the item on the input channel
  bit row_typed = 1'b0;
  int row_cnt = 0;
  logic [2:0][9:0] row_want = '0;

  // transcoder state as predicted
  bit be_order;
  bit unit_half;
  logic [7:0] held;
  bit pend_high;
  logic [9:0] high_bits;
  bit halted;

  utf8_res_t step_out[$];
  utf8_res_t utf8_pending[$];
  stim_row_t directed_rows[$];

  utt_in_if  in_chan();
  utt_out_if out_chan();

  assign in_chan.valid   = src_valid;
  assign in_chan.in_byte = src_byte;
  assign in_chan.in_last = src_last;
  assign out_chan.ready  = sink_ready;

  utf16_to_utf8_transcoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver stalls in bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      sink_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      sink_ready <= 1'b0;
      stall_left <= $urandom_range(0, 17);
    end else begin
      sink_ready <= 1'b1;
    end
  end

  task automatic clear_string();
    unit_half = 1'b0;
    held = 8'h00;
    pend_high = 1'b0;
    high_bits = 10'h000;
    halted = 1'b0;
  endtask

  task automatic push_res(input logic [7:0] b, input utt_pkg::kind_t k);
    utf8_res_t r;
    r.b = b;
    r.kind = k;
    r.last = 1'b0;
    step_out.push_back(r);
  endtask

  // utf-8 encoding of one code point
  task automatic push_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      push_res(cp[7:0], utt_pkg::KIND_DATA);
    end else if (cp < 21'h800) begin
      push_res({3'b110, cp[10:6]}, utt_pkg::KIND_DATA);
      push_res({2'b10, cp[5:0]}, utt_pkg::KIND_DATA);
    end else if (cp < 21'h10000) begin
      push_res({4'b1110, cp[15:12]}, utt_pkg::KIND_DATA);
      push_res({2'b10, cp[11:6]}, utt_pkg::KIND_DATA);
      push_res({2'b10, cp[5:0]}, utt_pkg::KIND_DATA);
    end else begin
      push_res({5'b11110, cp[20:18]}, utt_pkg::KIND_DATA);
      push_res({2'b10, cp[17:12]}, utt_pkg::KIND_DATA);
      push_res({2'b10, cp[11:6]}, utt_pkg::KIND_DATA);
      push_res({2'b10, cp[5:0]}, utt_pkg::KIND_DATA);
    end
  endtask

  // results caused by one utf-16 byte, left in step_out
  task automatic transcode_byte(input logic [7:0] b, input logic last);
    logic [15:0] unit;
    bit is_high;
    bit is_low;
    bit bad;
    step_out.delete();
    bad = 1'b0;
    if (halted) begin
      if (last)
        clear_string();
      return;
    end
    if (!unit_half) begin
      held = b;
      unit_half = 1'b1;
      if (last)
        bad = 1'b1;
    end else begin
      unit = be_order ? {held, b} : {b, held};
      is_high = unit >= 16'hD800 && unit <= 16'hDBFF;
      is_low = unit >= 16'hDC00 && unit <= 16'hDFFF;
      unit_half = 1'b0;
      held = 8'h00;
      if (pend_high) begin
        if (is_low) begin
          push_code_point(21'h10000 + {high_bits, unit[9:0]});
          pend_high = 1'b0;
          high_bits = 10'h000;
        end else begin
          bad = 1'b1;
        end
      end else if (is_high) begin
        if (last) begin
          bad = 1'b1;
        end else begin
          pend_high = 1'b1;
          high_bits = unit[9:0];
        end
      end else if (is_low) begin
        bad = 1'b1;
      end else begin
        push_code_point({5'd0, unit});
      end
    end
    if (bad) begin
      push_res(8'h00, utt_pkg::KIND_ERROR);
      if (last)
        clear_string();
      else
        halted = 1'b1;
    end else if (last) begin
      push_res(8'h00, utt_pkg::KIND_CLEAN);
      clear_string();
    end
    if (step_out.size() != 0)
      step_out[step_out.size() - 1].last = 1'b1;
  endtask

  // check result items, track config, predict on each accepted byte
  always @(posedge clk) begin
    utf8_res_t got;
    utf8_res_t want;
    utf8_res_t r;
    if (!rst_n) begin
      be_order = 1'b0;
      clear_string();
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got.b = out_chan.out_byte;
        got.kind = utt_pkg::kind_t'(out_chan.out_kind);
        got.last = out_chan.out_last;
        if (utf8_pending.size() == 0) begin
          if (mismatch_count < REPORT_MAX)
            $display("unexpected item at cycle %0d: byte %h kind %0d last %b",
                     cycle_count, got.b, got.kind, got.last);
          mismatch_count++;
        end else begin
          want = utf8_pending.pop_front();
          if (got.b !== want.b || got.kind !== want.kind || got.last !== want.last) begin
            if (mismatch_count < REPORT_MAX)
              $display({"mismatch at cycle %0d: expected byte %h kind %0d last %b,",
                        " got byte %h kind %0d last %b"},
                       cycle_count, want.b, want.kind, want.last,
                       got.b, got.kind, got.last);
            mismatch_count++;
          end
        end
      end
      if (cfg_we)
        be_order = cfg_wdata;
      if (in_chan.valid && in_chan.ready) begin
        transcode_byte(in_chan.in_byte, in_chan.in_last);
        if (row_typed) begin
          for (int i = 0; i < row_cnt; i++) begin
            r.b = row_want[i][7:0];
            r.kind = utt_pkg::kind_t'(row_want[i][9:8]);
            r.last = (i == row_cnt - 1);
            utf8_pending.push_back(r);
          end
        end else begin
          foreach (step_out[i])
            utf8_pending.push_back(step_out[i]);
        end
      end
    end
  end

  task automatic add_row(input logic [7:0] b, input logic last, input bit typed,
                         input int cnt, input logic [9:0] w0 = NO_ITEM,
                         input logic [9:0] w1 = NO_ITEM, input logic [9:0] w2 = NO_ITEM);
    stim_row_t row;
    row.b = b;
    row.last = last;
    row.typed = typed;
    row.cnt = cnt;
    row.want = {w2, w1, w0};
    directed_rows.push_back(row);
  endtask

  // one byte on the input channel, then maybe a sender gap
  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed = 1'b0,
                           input int cnt = 0, input logic [2:0][9:0] want = '0);
    int gap;
    @(negedge clk);
    src_valid <= 1'b1;
    src_byte <= b;
    src_last <= last;
    row_typed <= typed;
    row_cnt <= cnt;
    row_want <= want;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      src_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // hold the sender until every expected item is out and the block is quiet
  task automatic drain();
    @(negedge clk);
    src_valid <= 1'b0;
    while (utf8_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_order(input logic v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random string of code points, mostly well formed
  task automatic send_random_string(input flaw_t flaw);
    logic [15:0] units[$];
    logic [7:0] bytes_q[$];
    logic [15:0] partner;
    int r;
    int pos;
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: units.push_back(16'($urandom_range(0, 'h7F)));
        3, 4: units.push_back(16'($urandom_range('h80, 'h7FF)));
        5, 6: begin
          r = $urandom_range('h800, 'hF7FF);
          if (r >= 'hD800)
            r += 'h800;
          units.push_back(16'(r));
        end
        default: begin
          units.push_back(16'hD800 + 16'($urandom_range(0, 1023)));
          units.push_back(16'hDC00 + 16'($urandom_range(0, 1023)));
        end
      endcase
    end
    pos = $urandom_range(0, units.size());
    case (flaw)
      FLAW_LONE_LOW: units.insert(pos, 16'hDC00 + 16'($urandom_range(0, 1023)));
      FLAW_BAD_PAIR: begin
        partner = 16'($urandom_range(0, 'hFFFF));
        if (partner >= 16'hDC00 && partner <= 16'hDFFF)
          partner ^= 16'h0400;
        units.insert(pos, partner);
        units.insert(pos, 16'hD800 + 16'($urandom_range(0, 1023)));
      end
      FLAW_HIGH_AT_END: units.push_back(16'hD800 + 16'($urandom_range(0, 1023)));
      default: ;
    endcase
    foreach (units[i]) begin
      if (be_order) begin
        bytes_q.push_back(units[i][15:8]);
        bytes_q.push_back(units[i][7:0]);
      end else begin
        bytes_q.push_back(units[i][7:0]);
        bytes_q.push_back(units[i][15:8]);
      end
    end
    if (flaw == FLAW_ODD_BYTE)
      bytes_q.push_back(8'($urandom_range(0, 255)));
    if (flaw == FLAW_NOISE) begin
      bytes_q.delete();
      repeat ($urandom_range(1, 8))
        bytes_q.push_back(8'($urandom_range(0, 255)));
    end
    foreach (bytes_q[i])
      send_byte(bytes_q[i], i == bytes_q.size() - 1);
  endtask

  task automatic run_random(input int count, input bit pause_mid);
    int target;
    int half;
    target = items_sent + count;
    half = items_sent + count / 2;
    while (items_sent < target) begin
      if ($urandom_range(0, 4) == 0)
        send_random_string(flaw_t'($urandom_range(FLAW_LONE_LOW, FLAW_NOISE)));
      else
        send_random_string(FLAW_NONE);
      if (pause_mid && items_sent >= half) begin
        drain();
        pause_mid = 1'b0;
      end
    end
    drain();
  endtask

  initial begin
    // extremes and special cases, little-endian order after reset
    add_row(8'h00, 1'b0, 1'b1, 0);
    add_row(8'h00, 1'b0, 1'b1, 1, {utt_pkg::KIND_DATA, 8'h00});
    add_row(8'h7F, 1'b0, 1'b1, 0);
    add_row(8'h00, 1'b0, 1'b1, 1, {utt_pkg::KIND_DATA, 8'h7F});
    add_row(8'h80, 1'b0, 1'b1, 0);
    add_row(8'h00, 1'b0, 1'b1, 2, {utt_pkg::KIND_DATA, 8'hC2},
            {utt_pkg::KIND_DATA, 8'h80});
    add_row(8'hFF, 1'b0, 1'b1, 0);
    add_row(8'hFF, 1'b0, 1'b1, 3, {utt_pkg::KIND_DATA, 8'hEF},
            {utt_pkg::KIND_DATA, 8'hBF}, {utt_pkg::KIND_DATA, 8'hBF});
    // lowest and highest surrogate pairs
    add_row(8'h00, 1'b0, 1'b1, 0);
    add_row(8'hD8, 1'b0, 1'b1, 0);
    add_row(8'h00, 1'b0, 1'b0, 0);
    add_row(8'hDC, 1'b0, 1'b0, 0);
    add_row(8'hFF, 1'b0, 1'b0, 0);
    add_row(8'hDB, 1'b0, 1'b0, 0);
    add_row(8'hFF, 1'b0, 1'b0, 0);
    add_row(8'hDF, 1'b1, 1'b0, 0);
    // one-byte string
    add_row(8'hFF, 1'b1, 1'b1, 1, ERROR_END);
    // lone low surrogate
    add_row(8'h00, 1'b0, 1'b1, 0);
    add_row(8'hDC, 1'b1, 1'b1, 1, ERROR_END);
    // high surrogate then a plain unit, rest of string dropped
    add_row(8'h00, 1'b0, 1'b1, 0);
    add_row(8'hD8, 1'b0, 1'b1, 0);
    add_row(8'h41, 1'b0, 1'b1, 0);
    add_row(8'h00, 1'b0, 1'b1, 1, ERROR_END);
    add_row(8'h7E, 1'b1, 1'b1, 0);
    // high surrogate as the final unit
    add_row(8'h00, 1'b0, 1'b1, 0);
    add_row(8'hD8, 1'b1, 1'b1, 1, ERROR_END);

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].b, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].cnt, directed_rows[i].want);
    drain();

    write_order(1'b1);
    run_random(PHASE_ITEMS, 1'b0);
    write_order(1'b0);
    run_random(PHASE_ITEMS, 1'b1);
    // last part runs with no idling on either side
    write_order(1'b1);
    idle_on = 1'b0;
    run_random(PHASE_ITEMS, 1'b0);

    if (mismatch_count == 0 && utf8_pending.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

FILE: utf16_to_utf8_transcoder.f
hw/rtl/utt_pkg.sv
hw/rtl/utt_in_if.sv
hw/rtl/utt_out_if.sv
hw/rtl/utt_front.sv
hw/rtl/utt_fifo.sv
hw/rtl/utt_back.sv
hw/rtl/utf16_to_utf8_transcoder.sv
test/testbench.sv
